// ===== rtl/core/mcre_pkg.sv =====
// package for the multi-channel read engine: item types, codes and defaults
package mcre_pkg;

    // default configuration of the engine
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int ADDR_WIDTH_DEF   = 32;
    localparam int COUNT_WIDTH_DEF  = 16;

    // fixed widths of the item fields
    localparam int ADDR_FW    = 32;
    localparam int LEN_FW     = 16;
    localparam int CHAN_FW    = 3;
    localparam int DATA_FW    = 8;
    localparam int STATUS_FW  = 3;

    // command codes
    typedef enum logic {
        CMD_START = 1'b0,
        CMD_BYTE  = 1'b1
    } t_cmd;

    // result status codes
    typedef enum logic [STATUS_FW-1:0] {
        ST_STARTED  = 3'd0,
        ST_STORED   = 3'd1,
        ST_NO_FREE  = 3'd2,
        ST_IDLE_CH  = 3'd3,
        ST_ZERO_LEN = 3'd4
    } t_status;

    // one input item
    typedef struct packed {
        t_cmd               command;
        logic [ADDR_FW-1:0] start_address;
        logic [LEN_FW-1:0]  length;
        logic [CHAN_FW-1:0] channel;
        logic [DATA_FW-1:0] data_byte;
    } t_in_item;

    // one result item
    typedef struct packed {
        t_status            status;
        logic [CHAN_FW-1:0] channel_used;
        logic [ADDR_FW-1:0] write_address;
        logic [DATA_FW-1:0] write_data;
        logic               last;
    } t_out_item;

endpackage

// ===== rtl/core/mcre_chan_tbl.sv =====
// channel table: per-channel address and count, active mask, result logic
module mcre_chan_tbl #(
    parameter int NUM_CHANNELS = mcre_pkg::NUM_CHANNELS_DEF,
    parameter int ADDR_WIDTH   = mcre_pkg::ADDR_WIDTH_DEF,
    parameter int COUNT_WIDTH  = mcre_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mcre_pkg::t_in_item  i_item,
    output mcre_pkg::t_out_item o_result
);

    localparam int CH_IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [NUM_CHANNELS-1:0] r_active;
    logic [NUM_CHANNELS-1:0] n_active;
    logic [ADDR_WIDTH-1:0]   r_addr [NUM_CHANNELS];
    logic [COUNT_WIDTH-1:0]  r_cnt  [NUM_CHANNELS];

    logic                    free_found;
    logic [CH_IW-1:0]        free_idx;
    logic [CH_IW-1:0]        ch_idx;
    logic                    ch_ok;
    logic [ADDR_WIDTH-1:0]   addr_in;
    logic [COUNT_WIDTH-1:0]  len_in;
    logic [COUNT_WIDTH-1:0]  cnt_dec;
    logic                    wr_en;
    logic [CH_IW-1:0]        wr_idx;
    logic [ADDR_WIDTH-1:0]   wr_addr;
    logic [COUNT_WIDTH-1:0]  wr_cnt;
    mcre_pkg::t_out_item     res;

    // fields reduced to the table widths
    assign addr_in = ADDR_WIDTH'(i_item.start_address);
    assign len_in  = COUNT_WIDTH'(i_item.length);
    assign ch_idx  = CH_IW'(i_item.channel);
    assign ch_ok   = (32'(i_item.channel) < 32'(NUM_CHANNELS)) && r_active[ch_idx];
    assign cnt_dec = r_cnt[ch_idx] - COUNT_WIDTH'(1);

    // lowest free channel
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = CH_IW'(i);
            end
        end
    end

    // result and table update for the current item
    always_comb begin
        n_active = r_active;
        wr_en    = 1'b0;
        wr_idx   = '0;
        wr_addr  = '0;
        wr_cnt   = '0;
        res      = '0;
        case (i_item.command)
            mcre_pkg::CMD_START: begin
                if (len_in == '0) begin
                    res.status = mcre_pkg::ST_ZERO_LEN;
                end else if (!free_found) begin
                    res.status = mcre_pkg::ST_NO_FREE;
                end else begin
                    res.status           = mcre_pkg::ST_STARTED;
                    res.channel_used     = mcre_pkg::CHAN_FW'(free_idx);
                    res.write_address    = mcre_pkg::ADDR_FW'(addr_in);
                    n_active[free_idx]   = 1'b1;
                    wr_en                = 1'b1;
                    wr_idx               = free_idx;
                    wr_addr              = addr_in;
                    wr_cnt               = len_in;
                end
            end
            mcre_pkg::CMD_BYTE: begin
                res.channel_used = i_item.channel;
                if (!ch_ok) begin
                    res.status = mcre_pkg::ST_IDLE_CH;
                end else begin
                    res.status        = mcre_pkg::ST_STORED;
                    res.write_address = mcre_pkg::ADDR_FW'(r_addr[ch_idx]);
                    res.write_data    = i_item.data_byte;
                    res.last          = (cnt_dec == '0);
                    wr_en             = 1'b1;
                    wr_idx            = ch_idx;
                    wr_addr           = r_addr[ch_idx] + ADDR_WIDTH'(1);
                    wr_cnt            = cnt_dec;
                    if (cnt_dec == '0) begin
                        n_active[ch_idx] = 1'b0;
                    end
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign o_result = res;

    // active mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_en) begin
            r_active <= n_active;
        end
    end

    // address and count table, written before any read of an entry
    always_ff @(posedge i_clk) begin
        if (i_en && wr_en) begin
            r_addr[wr_idx] <= wr_addr;
            r_cnt[wr_idx]  <= wr_cnt;
        end
    end

`ifndef SYNTHESIS
    // a started transfer leaves its channel active
    a_start_sets_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && res.status == mcre_pkg::ST_STARTED) |=> r_active[$past(free_idx)])
        else $error("started channel not marked active");

    // the final byte of a transfer frees its channel
    a_last_clears_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && res.status == mcre_pkg::ST_STORED && res.last)
        |=> !r_active[$past(ch_idx)])
        else $error("channel still active after last byte");

    // no free channel is reported only when every channel is busy
    a_no_free_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && res.status == mcre_pkg::ST_NO_FREE) |-> (&r_active))
        else $error("no free channel reported with an idle channel");
`endif

endmodule

// ===== rtl/core/multi_channel_read_engine_unit.sv =====
// multi-channel read engine top level: input register, channel table, result register
// an item passes the input register and the channel table into the result register
// one item per cycle unless output stalls; the table reads and updates in one pass
// a stalled result register holds back the input register, which then drops ready
// reset (synchronous, active low) clears both valid flags and all channel active bits
// address and count entries are left as they are and are loaded by each start
module multi_channel_read_engine_unit #(
    parameter int NUM_CHANNELS = mcre_pkg::NUM_CHANNELS_DEF,
    parameter int ADDR_WIDTH   = mcre_pkg::ADDR_WIDTH_DEF,
    parameter int COUNT_WIDTH  = mcre_pkg::COUNT_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mcre_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mcre_pkg::t_out_item o_out_data
);

    logic                r_in_vld;
    mcre_pkg::t_in_item  r_in;
    logic                r_out_vld;
    mcre_pkg::t_out_item r_out;
    logic                adv;
    mcre_pkg::t_out_item tbl_res;

    // item moves on when the result register is free or being drained
    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // channel table and result logic
    mcre_chan_tbl #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .ADDR_WIDTH   (ADDR_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_chan_tbl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_item   (r_in),
        .o_result (tbl_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= tbl_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // a held item reaches the result register when that register is empty
    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !r_out_vld) |=> r_out_vld)
        else $error("held item did not move to result register");

    // ready drops only while both registers hold a stalled item
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_vld && r_out_vld && !i_out_ready))
        else $error("input stalled without a stalled result");

    // a drained result with nothing behind it leaves the result register empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_ready && !r_in_vld) |=> !r_out_vld)
        else $error("result repeated after transfer");
`endif

endmodule
